// ----- rtl/lsad_pkg.sv -----
// Shared types, constants and the arctangent table for the lidar sample block.
// Used by every cell module and by the top level.
`timescale 1ns / 1ps
`default_nettype none
package lsad_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_LEN      = 24;
   localparam int CORDIC_RUN    = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
   localparam int DIV_STEPS     = 39;
   localparam int MOD_STEPS     = 10;
   localparam int FULL_TURN     = 23040;
   localparam int FRAC_BITS     = 16;

   localparam logic [40:0] TURN_FIX  = 41'(FULL_TURN) << FRAC_BITS;
   localparam logic [40:0] TURN_BIAS = TURN_FIX << 7;

   typedef struct packed {
      logic        [14:0] range_mm;
      logic        [14:0] first;
      logic               no_range;
      logic               interp_en;
      logic               neg;
      logic        [7:0]  divisor;
      logic        [8:0]  rem;
      logic        [38:0] num;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic        [40:0] tot;
   } lsad_word_type;

   function automatic logic signed [31:0] atan_entry(input logic [4:0] idx);
      case (idx)
         5'd0:    return 32'sd188743680;
         5'd1:    return 32'sd111421900;
         5'd2:    return 32'sd58872272;
         5'd3:    return 32'sd29884485;
         5'd4:    return 32'sd15000234;
         5'd5:    return 32'sd7507429;
         5'd6:    return 32'sd3754631;
         5'd7:    return 32'sd1877430;
         5'd8:    return 32'sd938729;
         5'd9:    return 32'sd469366;
         5'd10:   return 32'sd234683;
         5'd11:   return 32'sd117342;
         5'd12:   return 32'sd58671;
         5'd13:   return 32'sd29335;
         5'd14:   return 32'sd14668;
         5'd15:   return 32'sd7334;
         5'd16:   return 32'sd3667;
         5'd17:   return 32'sd1833;
         5'd18:   return 32'sd917;
         5'd19:   return 32'sd458;
         5'd20:   return 32'sd229;
         5'd21:   return 32'sd115;
         5'd22:   return 32'sd57;
         5'd23:   return 32'sd29;
         default: return 32'sd0;
      endcase
   endfunction

endpackage
`default_nettype wire

// ----- rtl/lsad_cordic_cell.sv -----
// One vectoring CORDIC rotation on the x, y, z lanes of a word.
// Depends on lsad_pkg for the word type and arctangent table.
`timescale 1ns / 1ps
`default_nettype none
module lsad_cordic_cell
   import lsad_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [4:0]    step,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire lsad_word_type in_word,
   output logic               out_valid,
   input  wire logic          out_ready,
   output lsad_word_type      out_word
);

   logic          valid_ff;
   lsad_word_type word_ff, word_in;
   logic signed [31:0] dx, dy, ang;

   always_comb begin
      dx      = in_word.y >>> step;
      dy      = in_word.x >>> step;
      ang     = atan_entry(step);
      word_in = in_word;
      if (in_word.y > 32'sd0) begin
         word_in.x = in_word.x + dx;
         word_in.y = in_word.y - dy;
         word_in.z = in_word.z + ang;
      end else begin
         word_in.x = in_word.x - dx;
         word_in.y = in_word.y + dy;
         word_in.z = in_word.z - ang;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/lsad_div_cell.sv -----
// One restoring-division step: one quotient bit of the interpolation term.
// Depends on lsad_pkg for the word type.
`timescale 1ns / 1ps
`default_nettype none
module lsad_div_cell
   import lsad_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire lsad_word_type in_word,
   output logic               out_valid,
   input  wire logic          out_ready,
   output lsad_word_type      out_word
);

   logic          valid_ff;
   lsad_word_type word_ff, word_in;
   logic [47:0]   sh;
   logic [8:0]    rem_sh;

   always_comb begin
      sh      = {in_word.rem, in_word.num} << 1;
      rem_sh  = sh[47:39];
      word_in = in_word;
      if (rem_sh >= {1'b0, in_word.divisor}) begin
         word_in.rem = rem_sh - {1'b0, in_word.divisor};
         word_in.num = sh[38:0] | 39'd1;
      end else begin
         word_in.rem = rem_sh;
         word_in.num = sh[38:0];
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/lsad_mod_cell.sv -----
// One conditional subtract of a shifted full turn, reducing the angle total.
// Depends on lsad_pkg for the word type and turn constant.
`timescale 1ns / 1ps
`default_nettype none
module lsad_mod_cell
   import lsad_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [3:0]    step,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire lsad_word_type in_word,
   output logic               out_valid,
   input  wire logic          out_ready,
   output lsad_word_type      out_word
);

   logic          valid_ff;
   lsad_word_type word_ff, word_in;
   logic [40:0]   thr;

   always_comb begin
      thr     = TURN_FIX << step;
      word_in = in_word;
      if (in_word.tot >= thr) begin
         word_in.tot = in_word.tot - thr;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/lidar_sample_angle_distance.sv -----
// Lidar sample block: rounded distance and corrected, interpolated angle.
// Channels: req_ carries one sample word, rsp_ returns one result word for each.
// Both channels use valid/ready; a word moves when valid and ready are high.
// Path: a word passes through the prep stage, 16 CORDIC cells, 39 divider
// cells, the sum stage, 10 turn-reduction cells and the output stage.
// Throughput: one word per cycle; every cell is a register stage with its own
// valid bit, so a new word enters each cycle while the chain keeps moving.
// Each cell accepts when empty or when its neighbor takes its word, so when the
// receiver stalls, bubbles in the chain still fill and req_ready drops only
// once every stage is occupied.
// Reset clears all stage valid bits; no word is in flight afterwards.
`timescale 1ns / 1ps
`default_nettype none
module lidar_sample_angle_distance
   import lsad_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_first_angle_raw,
   input  wire logic [15:0] req_last_angle_raw,
   input  wire logic [7:0]  req_sample_count,
   input  wire logic [7:0]  req_sample_index,
   input  wire logic [15:0] req_distance_raw,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [14:0]      rsp_distance_mm,
   output logic [14:0]      rsp_angle_sixtyfourths,
   output logic             rsp_no_range
);

   // prep stage
   lsad_word_type      prep_in, prep_ff;
   logic               prep_valid_ff;
   logic [14:0]        first_a, last_a;
   logic signed [16:0] diff;
   logic [14:0]        mag;
   logic [22:0]        prod;
   logic [16:0]        dsum;
   logic [14:0]        dist_w;
   logic signed [19:0] ytmp;

   always_comb begin
      first_a = req_first_angle_raw[15:1];
      last_a  = req_last_angle_raw[15:1];
      diff    = $signed({2'b00, last_a}) - $signed({2'b00, first_a});
      if (diff < 17'sd0) begin
         diff = diff + 17'sd23040;
      end
      mag    = diff[16] ? 15'(-diff) : diff[14:0];
      prod   = 23'(mag) * 23'(req_sample_index);
      dsum   = {1'b0, req_distance_raw} + 17'd2;
      dist_w = dsum[16:2];
      ytmp   = 20'sd1553 - $signed({5'd0, dist_w} * 20'd10);

      prep_in           = '0;
      prep_in.range_mm  = dist_w;
      prep_in.first     = first_a;
      prep_in.no_range  = (dist_w == 15'd0);
      prep_in.interp_en = (req_sample_count > 8'd1);
      prep_in.neg       = diff[16];
      prep_in.divisor   = req_sample_count - 8'd1;
      prep_in.num       = {prod, 16'd0};
      prep_in.x         = $signed({3'd0, 29'(dist_w * 15'd15530)});
      prep_in.y         = 32'(ytmp * 20'sd218);
   end

   // CORDIC chain
   logic          c_valid [CORDIC_RUN+1];
   logic          c_ready [CORDIC_RUN+1];
   lsad_word_type c_word  [CORDIC_RUN+1];

   assign req_ready  = !prep_valid_ff || c_ready[0];
   assign c_valid[0] = prep_valid_ff;
   assign c_word[0]  = prep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (req_ready) begin
         prep_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         prep_ff <= prep_in;
      end
   end

   for (genvar i = 0; i < CORDIC_RUN; i++) begin : g_cordic
      lsad_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step      (5'(i)),
         .in_valid  (c_valid[i]),
         .in_ready  (c_ready[i]),
         .in_word   (c_word[i]),
         .out_valid (c_valid[i+1]),
         .out_ready (c_ready[i+1]),
         .out_word  (c_word[i+1])
      );
   end

   // divider chain
   logic          d_valid [DIV_STEPS+1];
   logic          d_ready [DIV_STEPS+1];
   lsad_word_type d_word  [DIV_STEPS+1];

   assign d_valid[0]          = c_valid[CORDIC_RUN];
   assign d_word[0]           = c_word[CORDIC_RUN];
   assign c_ready[CORDIC_RUN] = d_ready[0];

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      lsad_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (d_valid[i]),
         .in_ready  (d_ready[i]),
         .in_word   (d_word[i]),
         .out_valid (d_valid[i+1]),
         .out_ready (d_ready[i+1]),
         .out_word  (d_word[i+1])
      );
   end

   // sum stage
   lsad_word_type      sum_in, sum_ff;
   logic               sum_valid_ff, sum_ready;
   logic signed [40:0] interp, corr;
   logic [40:0]        quot;

   always_comb begin
      quot   = {2'b00, d_word[DIV_STEPS].num};
      interp = '0;
      if (d_word[DIV_STEPS].interp_en) begin
         interp = d_word[DIV_STEPS].neg ? -$signed(quot) : $signed(quot);
      end
      corr = d_word[DIV_STEPS].no_range ? 41'sd0 : 41'(d_word[DIV_STEPS].z);
      sum_in     = d_word[DIV_STEPS];
      sum_in.tot = {10'd0, d_word[DIV_STEPS].first, 16'd0} + 41'(interp) + 41'(corr)
                 + TURN_BIAS;
   end

   logic          m_valid [MOD_STEPS+1];
   logic          m_ready [MOD_STEPS+1];
   lsad_word_type m_word  [MOD_STEPS+1];

   assign sum_ready          = !sum_valid_ff || m_ready[0];
   assign d_ready[DIV_STEPS] = sum_ready;
   assign m_valid[0]         = sum_valid_ff;
   assign m_word[0]          = sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (sum_ready) begin
         sum_valid_ff <= d_valid[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (sum_ready && d_valid[DIV_STEPS]) begin
         sum_ff <= sum_in;
      end
   end

   // turn reduction chain
   for (genvar i = 0; i < MOD_STEPS; i++) begin : g_mod
      lsad_mod_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step      (4'(MOD_STEPS - 1 - i)),
         .in_valid  (m_valid[i]),
         .in_ready  (m_ready[i]),
         .in_word   (m_word[i]),
         .out_valid (m_valid[i+1]),
         .out_ready (m_ready[i+1]),
         .out_word  (m_word[i+1])
      );
   end

   // output stage
   logic        out_valid_ff, out_ready;
   logic [14:0] dist_ff, dist_in, ang_ff, ang_in;
   logic        nr_ff;
   logic [31:0] rnd;
   logic [15:0] ang_w;

   always_comb begin
      rnd     = {1'b0, m_word[MOD_STEPS].tot[30:0]} + 32'd32768;
      ang_w   = rnd[31:16];
      ang_in  = (ang_w >= 16'(FULL_TURN)) ? 15'd0 : ang_w[14:0];
      dist_in = m_word[MOD_STEPS].range_mm;
   end

   assign out_ready          = !out_valid_ff || rsp_ready;
   assign m_ready[MOD_STEPS] = out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= m_valid[MOD_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && m_valid[MOD_STEPS]) begin
         dist_ff <= dist_in;
         ang_ff  <= ang_in;
         nr_ff   <= m_word[MOD_STEPS].no_range;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_distance_mm        = dist_ff;
   assign rsp_angle_sixtyfourths = ang_ff;
   assign rsp_no_range           = nr_ff;

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for lidar_sample_angle_distance: distance rounding and corrected angle.
// Directed table then random samples, checked against an in-bench distance and angle predictor.
// Depends on rtl/lsad_pkg.sv and rtl/lidar_sample_angle_distance.sv.
`timescale 1ns / 1ps
module tb
   import lsad_pkg::*;
();

   typedef struct {
      logic [15:0] first_raw;
      logic [15:0] last_raw;
      logic [7:0]  count;
      logic [7:0]  index;
      logic [15:0] dist_raw;
   } sample_type;

   typedef struct {
      logic [14:0] dist_mm;
      logic [14:0] angle;
      logic        no_range;
   } point_type;

   typedef struct {
      sample_type s;
      logic       typed;
      point_type  p;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_first_angle_raw;
   logic [15:0] req_last_angle_raw;
   logic [7:0]  req_sample_count;
   logic [7:0]  req_sample_index;
   logic [15:0] req_distance_raw;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [14:0] rsp_distance_mm;
   logic [14:0] rsp_angle_sixtyfourths;
   logic        rsp_no_range;

   point_type pending_points[$];
   int        error_count = 0;
   bit        stim_done = 0;
   bit        long_hold = 0;
   row_type   directed_rows[$];

   lidar_sample_angle_distance u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_first_angle_raw(req_first_angle_raw),
      .req_last_angle_raw(req_last_angle_raw),
      .req_sample_count(req_sample_count),
      .req_sample_index(req_sample_index),
      .req_distance_raw(req_distance_raw),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_distance_mm(rsp_distance_mm),
      .rsp_angle_sixtyfourths(rsp_angle_sixtyfourths),
      .rsp_no_range(rsp_no_range)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic longint floor_shift(longint v, int sh);
      return v >>> sh;
   endfunction

   function automatic longint atan_step(int i);
      case (i)
         0: return 188743680;  1: return 111421900;  2: return 58872272;
         3: return 29884485;   4: return 15000234;   5: return 7507429;
         6: return 3754631;    7: return 1877430;    8: return 938729;
         9: return 469366;     10: return 234683;    11: return 117342;
         12: return 58671;     13: return 29335;     14: return 14668;
         15: return 7334;      16: return 3667;      17: return 1833;
         18: return 917;       19: return 458;       20: return 229;
         21: return 115;       22: return 57;        23: return 29;
         default: return 0;
      endcase
   endfunction

   function automatic point_type locate_point(sample_type s);
      longint first, last, cnt, idx, d, diff, interp, corr, tot, turn, r, ang;
      longint x, y, dx, dy;
      point_type p;
      first = longint'(s.first_raw >> 1);
      last = longint'(s.last_raw >> 1);
      cnt = longint'(s.count);
      idx = longint'(s.index);
      d = (longint'(s.dist_raw) + 2) >> 2;
      interp = 0;
      corr = 0;
      diff = last - first;
      if (diff < 0) diff += FULL_TURN;
      if (cnt > 1) interp = (diff * idx * 65536) / (cnt - 1);
      if (d > 0) begin
         x = 15530 * d;
         y = 218 * (1553 - 10 * d);
         for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y > 0) begin
               x += dx; y -= dy; corr += atan_step(i);
            end else begin
               x -= dx; y += dy; corr -= atan_step(i);
            end
         end
      end
      tot = first * 65536 + interp + corr;
      turn = longint'(FULL_TURN) << FRAC_BITS;
      r = tot % turn;
      if (r < 0) r += turn;
      ang = (r + 32768) >> FRAC_BITS;
      if (ang >= FULL_TURN) ang -= FULL_TURN;
      p.dist_mm = d[14:0];
      p.angle = ang[14:0];
      p.no_range = (d == 0);
      return p;
   endfunction

   function automatic row_type mk(logic [15:0] f, logic [15:0] l, logic [7:0] c,
                                  logic [7:0] i, logic [15:0] dr, logic typed,
                                  logic [14:0] dm, logic [14:0] an, logic nr);
      row_type r;
      r.s = '{f, l, c, i, dr};
      r.typed = typed;
      r.p = '{dm, an, nr};
      return r;
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      int k;
      k = $urandom_range(0, 9);
      s.first_raw = 16'($urandom);
      s.last_raw = 16'($urandom);
      if (k < 7) begin
         s.first_raw = 16'($urandom_range(0, 46079));
         s.last_raw = 16'($urandom_range(0, 46079));
      end
      s.count = (k == 9) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(2, 255));
      s.index = (k == 8) ? 8'($urandom)
                         : 8'($urandom_range(0, s.count == 0 ? 0 : s.count - 1));
      case ($urandom_range(0, 3))
         0: s.dist_raw = 16'($urandom_range(0, 3));
         1: s.dist_raw = 16'($urandom_range(0, 2000));
         2: s.dist_raw = 16'($urandom_range(65530, 65535));
         default: s.dist_raw = 16'($urandom);
      endcase
      return s;
   endfunction

   task automatic send_sample(sample_type s);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_first_angle_raw <= s.first_raw;
      req_last_angle_raw <= s.last_raw;
      req_sample_count <= s.count;
      req_sample_index <= s.index;
      req_distance_raw <= s.dist_raw;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         pending_points.push_back(locate_point('{req_first_angle_raw, req_last_angle_raw,
            req_sample_count, req_sample_index, req_distance_raw}));
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_points.size() == 0) begin
            $display("%0t unexpected word: dist %0d angle %0d", $time,
               rsp_distance_mm, rsp_angle_sixtyfourths);
            error_count++;
         end else begin
            point_type e;
            e = pending_points.pop_front();
            if (e.dist_mm !== rsp_distance_mm) begin
               $display("%0t distance_mm exp %0d got %0d", $time, e.dist_mm, rsp_distance_mm);
               error_count++;
            end
            if (e.angle !== rsp_angle_sixtyfourths) begin
               $display("%0t angle exp %0d got %0d", $time, e.angle, rsp_angle_sixtyfourths);
               error_count++;
            end
            if (e.no_range !== rsp_no_range) begin
               $display("%0t no_range exp %0d got %0d", $time, e.no_range, rsp_no_range);
               error_count++;
            end
         end
      end
   end

   // drive receiver backpressure, with one long hold
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (!stim_done || pending_points.size() != 0) begin
         int hold;
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
            long_hold = 0;
         end
         hold = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
         if ($urandom_range(0, 3) == 0) hold = 0;
         rsp_ready <= (hold == 0);
         if (hold != 0) repeat (hold) @(negedge clock);
         else @(negedge clock);
      end
      rsp_ready <= 1'b1;
   end

   initial begin
      sample_type s;
      point_type p;
      reset = 1'b1;
      req_valid = 1'b0;
      req_first_angle_raw = '0;
      req_last_angle_raw = '0;
      req_sample_count = '0;
      req_sample_index = '0;
      req_distance_raw = '0;
      directed_rows.push_back(mk(16'd0, 16'd0, 8'd1, 8'd0, 16'd0, 1'b1,
         15'd0, 15'd0, 1'b1));
      directed_rows.push_back(mk(16'd1, 16'd1, 8'd0, 8'd0, 16'd1, 1'b1,
         15'd0, 15'd0, 1'b1));
      directed_rows.push_back(mk(16'd200, 16'd0, 8'd1, 8'd0, 16'd0, 1'b1,
         15'd0, 15'd100, 1'b1));
      directed_rows.push_back(mk(16'd46078, 16'd0, 8'd1, 8'd0, 16'd0, 1'b1,
         15'd0, 15'd23039, 1'b1));
      directed_rows.push_back(mk(16'hFFFF, 16'h0, 8'd1, 8'd0, 16'd0, 1'b1,
         15'd0, 15'd9727, 1'b1));
      directed_rows.push_back(mk(16'd0, 16'd0, 8'd1, 8'd0, 16'd65535, 1'b0,
         15'd0, 15'd0, 1'b0));
      directed_rows.push_back(mk(16'd0, 16'd0, 8'd1, 8'd0, 16'd2, 1'b0,
         15'd0, 15'd0, 1'b0));
      directed_rows.push_back(mk(16'd0, 16'd0, 8'd1, 8'd0, 16'd6212, 1'b0,
         15'd0, 15'd0, 1'b0));
      directed_rows.push_back(mk(16'd100, 16'd20, 8'd255, 8'd254, 16'd400, 1'b0,
         15'd0, 15'd0, 1'b0));
      directed_rows.push_back(mk(16'd0, 16'd46078, 8'd255, 8'd254, 16'd0, 1'b0,
         15'd0, 15'd0, 1'b0));
      directed_rows.push_back(mk(16'd1000, 16'd2000, 8'd10, 8'd255, 16'd1000, 1'b0,
         15'd0, 15'd0, 1'b0));
      directed_rows.push_back(mk(16'hFFFF, 16'hFFFF, 8'd255, 8'd0, 16'hFFFF, 1'b0,
         15'd0, 15'd0, 1'b0));
      directed_rows.push_back(mk(16'h5555, 16'hAAAA, 8'd2, 8'd1, 16'h5555, 1'b0,
         15'd0, 15'd0, 1'b0));
      directed_rows.push_back(mk(16'hAAAA, 16'h5555, 8'd128, 8'd127, 16'hAAAA, 1'b0,
         15'd0, 15'd0, 1'b0));
      directed_rows.push_back(mk(16'd46080, 16'd0, 8'd0, 8'd200, 16'd3, 1'b0,
         15'd0, 15'd0, 1'b0));
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].typed) begin
            p = locate_point(directed_rows[i].s);
            if (p !== directed_rows[i].p) begin
               $display("%0t row %0d exp %0d/%0d/%0d predictor %0d/%0d/%0d", $time, i,
                  directed_rows[i].p.dist_mm, directed_rows[i].p.angle,
                  directed_rows[i].p.no_range, p.dist_mm, p.angle, p.no_range);
               error_count++;
            end
         end
         send_sample(directed_rows[i].s);
      end
      for (int n = 0; n < 1700; n++) begin
         if (n == 600) long_hold = 1;
         s = random_sample();
         send_sample(s);
      end
      req_valid <= 1'b0;
      stim_done = 1;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #20000000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule

// ----- sim.f -----
rtl/lsad_pkg.sv
rtl/lsad_cordic_cell.sv
rtl/lsad_div_cell.sv
rtl/lsad_mod_cell.sv
rtl/lidar_sample_angle_distance.sv
tb/tb.sv
